/* rtl/core/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

/* rtl/core/twt_pkg.sv */
package twt_pkg;

  localparam int WHEEL_SLOTS  = 64;
  localparam int POOL_ENTRIES = 64;
  localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
  localparam int ENTRY_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int LINK_W  = $clog2(POOL_ENTRIES + 1);
  localparam int CNT_W   = $clog2(WHEEL_SLOTS + 1);
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_ENTRIES);

  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_CANCEL  = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [2:0] KIND_ADDED     = 3'd0;
  localparam logic [2:0] KIND_POOL_FULL = 3'd1;
  localparam logic [2:0] KIND_NEGATIVE  = 3'd2;
  localparam logic [2:0] KIND_CANCELLED = 3'd3;
  localparam logic [2:0] KIND_EXPIRED   = 3'd4;

  // Free-list link that an untouched pool entry holds after reset.
  function automatic logic [LINK_W-1:0] init_link(input logic [LINK_W-1:0] e);
    logic [LINK_W:0] n;
    n = {1'b0, e} + 1'b1;
    init_link = (n < (LINK_W+1)'(POOL_ENTRIES)) ? n[LINK_W-1:0] : NIL_LINK;
  endfunction

endpackage

/* rtl/core/timing_wheel_timer_unit.sv */
// Timing wheel timer.
// A request is taken when start is high and busy is low; operation selects
// add, cancel or advance. Each result appears for one cycle with strobe high
// and cannot be held off; last marks the final result of a request.
// Cancels and refused adds answer in the cycle after the request.
// An unknown operation is taken and answers nothing.
// An add or an advance first runs a shared one-bit-per-cycle divider. An
// advance then walks the expired slots, reading each slot head and then
// each entry found, and ends in a closing step. Each expired timer is
// reported when the next live entry is found, the final one in the closing
// step. tick_length is written over the APB port at address 0; the user
// must write it only while idle, as the block does not enforce this.
// After reset every slot is empty, all pool entries are free, the current
// slot and the reference time are zero and tick_length is 1. No clearing
// pass is needed; the block takes requests in the first cycle after reset.
`include "assert_macros.svh"
module timing_wheel_timer_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     operation,
  input  logic signed [31:0]             timeout,
  input  logic [31:0]                    payload,
  input  logic [5:0]                     handle,
  input  logic [31:0]                    now_time,
  output logic                           strobe,
  output logic [2:0]                     kind,
  output logic [5:0]                     entry_handle,
  output logic [31:0]                    expired_payload,
  output logic                           last,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import twt_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DIV      = 4'd1;
  localparam logic [3:0] ST_ADD_RD   = 4'd2;
  localparam logic [3:0] ST_ADD_WR   = 4'd3;
  localparam logic [3:0] ST_ADV_SLOT = 4'd4;
  localparam logic [3:0] ST_ADV_HEAD = 4'd5;
  localparam logic [3:0] ST_ADV_CHK  = 4'd6;
  localparam logic [3:0] ST_ADV_RD   = 4'd7;
  localparam logic [3:0] ST_ADV_ENT  = 4'd8;
  localparam logic [3:0] ST_ADV_END  = 4'd9;

  logic [3:0]        state;
  logic [15:0]       tick_length;
  logic [31:0]       last_time;
  logic [SLOT_W-1:0] current_slot;
  logic [LINK_W-1:0] free_head;
  logic              is_add;
  logic [31:0]       add_payload;
  logic [31:0]       adv_now;

  // Divider.
  logic [31:0] dvd;
  logic [16:0] rem;
  logic [4:0]  div_cnt;
  logic [15:0] tick_eff;
  logic [16:0] rem_sh;
  logic        rem_ge;
  logic [31:0] quot;

  // Walk state.
  logic [SLOT_W-1:0] slot;
  logic [LINK_W-1:0] eaddr;
  logic [CNT_W-1:0]  cnt;
  logic              pend_vld;
  logic [5:0]        pend_handle;
  logic [31:0]       pend_tag;

  // Memories with per-entry valid flags standing for reset contents.
  logic [LINK_W-1:0] slot_mem [WHEEL_SLOTS];
  logic [WHEEL_SLOTS-1:0] slot_vld;
  logic [LINK_W-1:0] next_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] next_vld;
  logic [31:0]       tag_mem [POOL_ENTRIES];
  logic              drop_mem [POOL_ENTRIES];
  logic [POOL_ENTRIES-1:0] drop_vld;

  logic [LINK_W-1:0] slot_raw, next_raw;
  logic              slot_rv, next_rv, drop_raw, drop_rv;
  logic [LINK_W-1:0] next_ra;
  logic [31:0]       tag_rd;
  logic [LINK_W-1:0] slot_rd, next_rd;
  logic              drop_rd;

  logic              slot_we, next_we, tag_we, drop_we;
  logic [LINK_W-1:0] slot_wd, next_wd;
  logic              drop_wd;
  logic [ENTRY_W-1:0] ent_wa;

  logic accept, cfg_wr;
  logic [SLOT_W-1:0] add_off;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {16'd0, tick_length};

  assign tick_eff = (tick_length == 16'd0) ? 16'd1 : tick_length;
  assign rem_sh   = {rem[15:0], dvd[31]};
  assign rem_ge   = (rem_sh >= {1'b0, tick_eff});
  assign quot     = {dvd[30:0], rem_ge};

  assign slot_rd = slot_rv ? slot_raw : NIL_LINK;
  assign next_rd = next_rv ? next_raw : init_link(next_ra);
  assign drop_rd = drop_rv ? drop_raw : 1'b0;
  assign ent_wa  = eaddr[ENTRY_W-1:0];

  // Slot offset of an add: max(q,1)-1, held at one turn less one slot.
  always_comb begin
    if (quot <= 32'd1) begin
      add_off = '0;
    end else if (quot > 32'(WHEEL_SLOTS)) begin
      add_off = SLOT_W'(WHEEL_SLOTS - 1);
    end else begin
      add_off = SLOT_W'(quot - 32'd1);
    end
  end

  always_comb begin
    slot_we = 1'b0;
    slot_wd = NIL_LINK;
    next_we = 1'b0;
    next_wd = free_head;
    tag_we  = 1'b0;
    drop_we = 1'b0;
    drop_wd = 1'b1;
    unique case (state)
      ST_ADD_WR: begin
        slot_we = 1'b1;
        slot_wd = eaddr;
        next_we = 1'b1;
        next_wd = slot_rd;
        tag_we  = 1'b1;
        drop_we = 1'b1;
        drop_wd = 1'b0;
      end
      ST_ADV_CHK: begin
        slot_we = (eaddr >= NIL_LINK);
      end
      ST_ADV_ENT: begin
        next_we = 1'b1;
        drop_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    slot_raw <= slot_mem[slot];
    slot_rv  <= slot_vld[slot];
    next_raw <= next_mem[ent_wa];
    next_rv  <= next_vld[ent_wa];
    next_ra  <= eaddr;
    tag_rd   <= tag_mem[ent_wa];
    drop_raw <= drop_mem[ent_wa];
    drop_rv  <= drop_vld[ent_wa];
    if (slot_we) begin
      slot_mem[slot] <= slot_wd;
    end
    if (next_we) begin
      next_mem[ent_wa] <= next_wd;
    end
    if (tag_we) begin
      tag_mem[ent_wa] <= add_payload;
    end
    if (drop_we) begin
      drop_mem[ent_wa] <= drop_wd;
    end else if (accept && operation == OP_CANCEL && 7'(handle) < 7'(POOL_ENTRIES)) begin
      drop_mem[handle[ENTRY_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      next_vld <= '0;
      drop_vld <= '0;
    end else begin
      if (slot_we) begin
        slot_vld[slot] <= 1'b1;
      end
      if (next_we) begin
        next_vld[ent_wa] <= 1'b1;
      end
      if (drop_we) begin
        drop_vld[ent_wa] <= 1'b1;
      end else if (accept && operation == OP_CANCEL && 7'(handle) < 7'(POOL_ENTRIES)) begin
        drop_vld[handle[ENTRY_W-1:0]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      tick_length     <= 16'd1;
      last_time       <= '0;
      current_slot    <= '0;
      free_head       <= '0;
      strobe          <= 1'b0;
      pend_vld        <= 1'b0;
      kind            <= KIND_ADDED;
      entry_handle    <= '0;
      expired_payload <= '0;
      last            <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_wr) begin
        tick_length <= pwdata[15:0];
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            is_add      <= (operation == OP_ADD);
            add_payload <= payload;
            adv_now     <= now_time;
            div_cnt     <= '0;
            rem         <= '0;
            pend_vld    <= 1'b0;
            entry_handle    <= '0;
            expired_payload <= '0;
            last            <= 1'b1;
            priority if (operation == OP_ADD && timeout[31]) begin
              strobe <= 1'b1;
              kind   <= KIND_NEGATIVE;
            end else if (operation == OP_ADD && free_head >= NIL_LINK) begin
              strobe <= 1'b1;
              kind   <= KIND_POOL_FULL;
            end else if (operation == OP_ADD) begin
              dvd   <= timeout;
              state <= ST_DIV;
            end else if (operation == OP_CANCEL) begin
              strobe <= 1'b1;
              kind   <= KIND_CANCELLED;
            end else if (operation == OP_ADVANCE) begin
              dvd   <= now_time - last_time;
              state <= ST_DIV;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_DIV: begin
          dvd     <= quot;
          rem     <= rem_ge ? (rem_sh - {1'b0, tick_eff}) : rem_sh;
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            if (is_add) begin
              slot  <= current_slot + add_off;
              eaddr <= free_head;
              state <= ST_ADD_RD;
            end else if (quot == 32'd0) begin
              state <= ST_IDLE;
            end else begin
              cnt       <= (quot > 32'(WHEEL_SLOTS)) ? CNT_W'(WHEEL_SLOTS) : CNT_W'(quot);
              last_time <= adv_now;
              slot      <= current_slot;
              state     <= ST_ADV_SLOT;
            end
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          free_head    <= next_rd;
          strobe       <= 1'b1;
          kind         <= KIND_ADDED;
          entry_handle <= 6'(eaddr);
          last         <= 1'b1;
          state        <= ST_IDLE;
        end
        ST_ADV_SLOT: begin
          state <= ST_ADV_HEAD;
        end
        ST_ADV_HEAD: begin
          eaddr <= slot_rd;
          state <= ST_ADV_CHK;
        end
        ST_ADV_CHK: begin
          if (eaddr >= NIL_LINK) begin
            slot <= slot + 1'b1;
            cnt  <= cnt - 1'b1;
            state <= (cnt == CNT_W'(1)) ? ST_ADV_END : ST_ADV_SLOT;
          end else begin
            state <= ST_ADV_RD;
          end
        end
        ST_ADV_RD: begin
          state <= ST_ADV_ENT;
        end
        ST_ADV_ENT: begin
          // A live entry is held back one step so the final one can carry last.
          if (!drop_rd) begin
            if (pend_vld) begin
              strobe          <= 1'b1;
              kind            <= KIND_EXPIRED;
              entry_handle    <= pend_handle;
              expired_payload <= pend_tag;
              last            <= 1'b0;
            end
            pend_vld    <= 1'b1;
            pend_handle <= 6'(eaddr);
            pend_tag    <= tag_rd;
          end
          free_head <= eaddr;
          eaddr     <= next_rd;
          state     <= ST_ADV_CHK;
        end
        ST_ADV_END: begin
          current_slot <= slot;
          if (pend_vld) begin
            strobe          <= 1'b1;
            kind            <= KIND_EXPIRED;
            entry_handle    <= pend_handle;
            expired_payload <= pend_tag;
            last            <= 1'b1;
          end
          pend_vld <= 1'b0;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_SAME(a_single_last, clk, rst, strobe && kind != KIND_EXPIRED, last)
  `ASSERT_NEXT(a_more_follow, clk, rst, strobe && kind == KIND_EXPIRED && !last, busy)
  `ASSERT_SAME(a_free_link, clk, rst, 1'b1, free_head <= NIL_LINK)
  `ASSERT_NEXT(a_div_len, clk, rst, state == ST_DIV && div_cnt != 5'd31, state == ST_DIV)

endmodule

/* tb/tb_timing_wheel_timer_unit.sv */
module tb_timing_wheel_timer_unit;
  import twt_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] operation = OP_ADD;
  logic signed [31:0] timeout = '0;
  logic [31:0] payload = '0;
  logic [5:0] handle = '0;
  logic [31:0] now_time = '0;
  logic strobe;
  logic [2:0] kind;
  logic [5:0] entry_handle;
  logic [31:0] expired_payload;
  logic last;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam logic [2:0] ADDR_TICK_LENGTH = 3'd0;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  entry;
    logic [31:0] tag;
    logic        last;
  } timer_event_t;

  timer_event_t pending_events[$];

  // Shadow of the wheel state.
  logic [15:0] tick_reg;
  logic [6:0]  heads[WHEEL_SLOTS];
  logic [6:0]  links[POOL_ENTRIES];
  logic [31:0] tags[POOL_ENTRIES];
  logic        dropped[POOL_ENTRIES];
  logic [6:0]  free_ptr;
  logic [5:0]  cur_slot;
  logic [31:0] ref_time;

  int errors = 0;
  int requests = 0;
  int events_seen = 0;
  int expiries_seen = 0;
  int cycles = 0;
  logic [31:0] sim_now = '0;

  timing_wheel_timer_unit u_top (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** timing_wheel_timer_unit: FAILED **");
      $finish;
    end
  end

  // Compares each result strobe with the oldest expected event.
  always @(posedge clk) begin
    timer_event_t got, exp_ev;
    if (!rst && strobe) begin
      got = '{kind, entry_handle, expired_payload, last};
      events_seen++;
      if (kind == KIND_EXPIRED) expiries_seen++;
      if (pending_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result kind=%0d handle=%0d tag=%h last=%0b",
                 $time, kind, entry_handle, expired_payload, last);
      end else begin
        exp_ev = pending_events.pop_front();
        if (got.kind !== exp_ev.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, exp_ev.kind, got.kind);
        end
        if (got.entry !== exp_ev.entry) begin
          errors++;
          $display("%0t: entry_handle expected %0d actual %0d", $time, exp_ev.entry,
                   got.entry);
        end
        if (got.tag !== exp_ev.tag) begin
          errors++;
          $display("%0t: expired_payload expected %h actual %h", $time, exp_ev.tag,
                   got.tag);
        end
        if (got.last !== exp_ev.last) begin
          errors++;
          $display("%0t: last expected %0b actual %0b", $time, exp_ev.last, got.last);
        end
      end
    end
  end

  function automatic void reset_wheel();
    tick_reg = 16'd1;
    for (int i = 0; i < WHEEL_SLOTS; i++) heads[i] = NIL_LINK;
    for (int i = 0; i < POOL_ENTRIES; i++) begin
      links[i] = (i + 1 < POOL_ENTRIES) ? 7'(i + 1) : NIL_LINK;
      tags[i] = '0;
      dropped[i] = 1'b0;
    end
    free_ptr = '0;
    cur_slot = '0;
    ref_time = '0;
  endfunction

  function automatic void predict_request(logic [1:0] op, logic [31:0] tmo,
                                          logic [31:0] tag, logic [5:0] h,
                                          logic [31:0] now);
    logic [31:0] div, n, count;
    logic [5:0] slot, e;
    logic [6:0] walk, nx;
    int found, guard;
    div = (tick_reg == 0) ? 32'd1 : {16'd0, tick_reg};
    found = 0;
    case (op)
      OP_ADD: begin
        if (tmo[31]) pending_events.push_back('{KIND_NEGATIVE, 6'd0, 32'd0, 1'b1});
        else if (free_ptr >= POOL_ENTRIES)
          pending_events.push_back('{KIND_POOL_FULL, 6'd0, 32'd0, 1'b1});
        else begin
          n = tmo / div;
          if (n < 1) n = 1;
          n = n - 1;
          if (n > WHEEL_SLOTS - 1) n = WHEEL_SLOTS - 1;
          slot = cur_slot + n[5:0];
          e = free_ptr[5:0];
          free_ptr = links[e];
          dropped[e] = 1'b0;
          tags[e] = tag;
          links[e] = heads[slot];
          heads[slot] = {1'b0, e};
          pending_events.push_back('{KIND_ADDED, e, 32'd0, 1'b1});
        end
      end
      OP_CANCEL: begin
        dropped[h] = 1'b1;
        pending_events.push_back('{KIND_CANCELLED, 6'd0, 32'd0, 1'b1});
      end
      OP_ADVANCE: begin
        count = (now - ref_time) / div;
        if (count != 0) begin
          if (count > WHEEL_SLOTS) count = WHEEL_SLOTS;
          ref_time = now;
          slot = cur_slot;
          for (int s = 0; s < count; s++) begin
            walk = heads[slot];
            guard = 0;
            while (walk < POOL_ENTRIES && guard < POOL_ENTRIES) begin
              nx = links[walk[5:0]];
              if (!dropped[walk[5:0]]) begin
                pending_events.push_back('{KIND_EXPIRED, walk[5:0], tags[walk[5:0]], 1'b0});
                found++;
              end
              dropped[walk[5:0]] = 1'b1;
              links[walk[5:0]] = free_ptr;
              free_ptr = walk;
              walk = nx;
              guard++;
            end
            heads[slot] = NIL_LINK;
            slot = slot + 1'b1;
          end
          cur_slot = slot;
          if (found > 0) pending_events[pending_events.size() - 1].last = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // Returns just after the accepting edge; start drops at the next falling
  // edge unless the following request is driven there with no gap.
  task automatic send_request(logic [1:0] op, logic [31:0] tmo, logic [31:0] tag,
                              logic [5:0] h, logic [31:0] now);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    timeout <= tmo;
    payload <= tag;
    handle <= h;
    now_time <= now;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_request(op, tmo, tag, h, now);
    requests++;
  endtask

  task automatic add_timer(logic [31:0] tmo);
    send_request(OP_ADD, tmo, $urandom, 6'($urandom), $urandom);
  endtask

  task automatic advance_by(logic [31:0] delta);
    sim_now = sim_now + delta;
    send_request(OP_ADVANCE, $urandom, $urandom, 6'($urandom), sim_now);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    // An advance that finds nothing may still be walking slots.
    repeat (400) @(negedge clk);
  endtask

  task automatic write_tick_length(logic [15:0] value);
    wait_drained();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_TICK_LENGTH;
    pwdata <= {16'($urandom), value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    tick_reg = value;
    @(negedge clk);
    if (prdata[15:0] !== value) begin
      errors++;
      $display("%0t: tick_length readback expected %0d actual %0d", $time, value,
               prdata[15:0]);
    end
  endtask

  task automatic test_directed_edges();
    add_timer(32'sd0);
    add_timer(32'sd1);
    add_timer(32'h7fff_ffff);
    add_timer(32'h8000_0000);
    add_timer(32'hffff_ffff);
    send_request(OP_CANCEL, '0, '0, 6'd1, '0);
    send_request(OP_CANCEL, '0, '0, 6'd63, '0);
    send_request(2'd3, $urandom, $urandom, 6'($urandom), $urandom);
    advance_by(0);
    advance_by(1);
    advance_by(32'd200);
    send_request(OP_ADD, 32'd5, 32'hffff_ffff, 6'd0, '0);
    send_request(OP_ADD, 32'd5, 32'h0000_0000, 6'd0, '0);
    advance_by(32'd6);
  endtask

  task automatic test_pool_exhaustion();
    for (int i = 0; i < 66; i++) add_timer(32'($urandom_range(1, 300)));
    add_timer(32'sd10);
    add_timer(-32'sd5);
    advance_by(32'hffff_fff0);
  endtask

  task automatic test_random_traffic(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 9) add_timer($urandom_range(0, 9) == 0 ? $urandom :
                              32'($urandom_range(0, 90 * tick_reg + 5)));
      else if (pick < 12) send_request(OP_CANCEL, $urandom, $urandom, 6'($urandom), $urandom);
      else if (pick < 19) advance_by($urandom_range(0, 9) == 0 ? $urandom :
                                     32'($urandom_range(0, 12 * tick_reg)));
      else send_request(2'd3, $urandom, $urandom, 6'($urandom), $urandom);
    end
  endtask

  initial begin
    reset_wheel();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_pool_exhaustion();
    test_random_traffic(120);
    write_tick_length(16'd0);
    test_random_traffic(60);
    write_tick_length(16'hffff);
    test_random_traffic(60);
    write_tick_length(16'd7);
    test_random_traffic(100);
    write_tick_length(16'd1);
    test_random_traffic(30);
    wait_drained();
    $display("Sent %0d requests over tick lengths 1, 0, 65535 and 7; checked %0d results,",
             requests, events_seen);
    $display("%0d of them expiries, including pool exhaustion and refusals.", expiries_seen);
    if (errors == 0) $display("** timing_wheel_timer_unit: PASSED **");
    else $display("** timing_wheel_timer_unit: FAILED **");
    $finish;
  end

endmodule
